FILE: rtl/core/ils_pkg.sv
// Shared constants, codes and control types of the indexed list store.
package ils_pkg;

  // Storage geometry
  localparam int CAPACITY     = 64;
  localparam int ELEMENT_BITS = 32;
  localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  // Request and response field widths
  localparam int COMMAND_W = 3;
  localparam int INDEX_W   = 6;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int READ_W    = 32;
  localparam int LENGTH_W  = 7;

  // Width used to compare a request index against the element count
  localparam int WIDE_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_READ   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_INSERT = 3'd4,
    CMD_REMOVE = 3'd5,
    CMD_SWAP   = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What the row of cells does this cycle
  typedef enum logic [1:0] {
    MODE_HOLD,    // every cell keeps its element
    MODE_WRITE,   // the cell at idx loads the load data
    MODE_INSERT,  // cells above idx take from below, cell at idx loads
    MODE_REMOVE   // cells at and above idx take from above
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [IDX_W-1:0]   idx;   // target position
    logic [IDX_W-1:0]   last;  // position of the last element
  } ctl_t;

endpackage

FILE: rtl/core/ils_cmd_if.sv
// Request channel of the indexed list store.
interface ils_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [ils_pkg::COMMAND_W-1:0] command;
  logic [ils_pkg::INDEX_W-1:0]   index;
  logic [ils_pkg::VALUE_W-1:0]   value;

  modport source (output valid, command, index, value, input ready);
  modport sink   (input valid, command, index, value, output ready);
endinterface

FILE: rtl/core/ils_rsp_if.sv
// Response channel of the indexed list store.
interface ils_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ils_pkg::STATUS_W-1:0] status;
  logic [ils_pkg::READ_W-1:0]   read_value;
  logic [ils_pkg::LENGTH_W-1:0] length;

  modport source (output valid, status, read_value, length, input ready);
  modport sink   (input valid, status, read_value, length, output ready);
endinterface

FILE: rtl/core/indexed_list_store.sv
// Top level of the indexed list store: command decode, length and response register.
// An ordered list of up to CAPACITY elements held in a row of cells, one element per
// cell. Each request (push, pop, read, write, insert, remove, swap remove, clear) is
// decoded and applied in the clock edge at which it is accepted: every cell loads, takes
// from a neighbor or holds in parallel, so inserts and removes shift the whole tail
// at the same edge. The response is registered and shows in the cycle after
// acceptance; a new request is taken every cycle as long as the response is being
// taken or the response register is empty, giving one request per cycle sustained.
// A bad index or a pop on an empty list returns status 1, a push or valid insert on a
// full list returns status 2, and both leave the list unchanged. Element contents are
// not cleared by reset or by clear; only the length is.
module indexed_list_store (
  input  logic             clk,
  input  logic             rst,
  ils_cmd_if.sink          cmd,
  ils_rsp_if.source        rsp
);

  localparam int W  = ils_pkg::ELEMENT_BITS;
  localparam int CW = ils_pkg::CNT_W;
  localparam int XW = ils_pkg::WIDE_W;

  logic [CW-1:0]                    count;
  logic [CW-1:0]                    count_next;
  logic                             rsp_valid;
  logic [ils_pkg::STATUS_W-1:0]     rsp_status;
  logic [ils_pkg::READ_W-1:0]       rsp_read;
  logic [ils_pkg::LENGTH_W-1:0]     rsp_length;

  logic                             accept;
  ils_pkg::ctl_t                    ctl;
  logic [W-1:0]                     load_data;
  logic [W-1:0]                     rd_a;
  logic [W-1:0]                     rd_b;
  ils_pkg::status_t                 status_next;
  logic [W-1:0]                     read_next;
  logic [XW-1:0]                    idx_wide;
  logic [XW-1:0]                    cnt_wide;
  logic                             idx_ok;
  logic                             full;

  assign cmd.ready = !rsp_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign idx_wide = XW'(cmd.index);
  assign cnt_wide = XW'(count);
  assign idx_ok   = idx_wide < cnt_wide;
  assign full     = (count == CW'(ils_pkg::CAPACITY));

  // Decode the request into a row mode, status and new length
  always_comb begin
    ctl.mode    = ils_pkg::MODE_HOLD;
    ctl.idx     = ils_pkg::IDX_W'(cmd.index);
    ctl.last    = ils_pkg::IDX_W'(count - CW'(1));
    load_data   = W'(cmd.value);
    status_next = ils_pkg::ST_OK;
    read_next   = '0;
    count_next  = count;
    case (ils_pkg::cmd_t'(cmd.command))
      ils_pkg::CMD_PUSH: begin
        if (full) begin
          status_next = ils_pkg::ST_FULL;
        end else begin
          ctl.mode   = ils_pkg::MODE_WRITE;
          ctl.idx    = ils_pkg::IDX_W'(count);
          count_next = count + CW'(1);
        end
      end
      ils_pkg::CMD_POP: begin
        if (count == '0) begin
          status_next = ils_pkg::ST_RANGE;
        end else begin
          read_next  = rd_b;
          count_next = count - CW'(1);
        end
      end
      ils_pkg::CMD_READ: begin
        if (!idx_ok) status_next = ils_pkg::ST_RANGE;
        else read_next = rd_a;
      end
      ils_pkg::CMD_WRITE: begin
        if (!idx_ok) status_next = ils_pkg::ST_RANGE;
        else ctl.mode = ils_pkg::MODE_WRITE;
      end
      ils_pkg::CMD_INSERT: begin
        if (idx_wide > cnt_wide) begin
          status_next = ils_pkg::ST_RANGE;
        end else if (full) begin
          status_next = ils_pkg::ST_FULL;
        end else begin
          ctl.mode   = ils_pkg::MODE_INSERT;
          count_next = count + CW'(1);
        end
      end
      ils_pkg::CMD_REMOVE: begin
        if (!idx_ok) begin
          status_next = ils_pkg::ST_RANGE;
        end else begin
          ctl.mode   = ils_pkg::MODE_REMOVE;
          read_next  = rd_a;
          count_next = count - CW'(1);
        end
      end
      ils_pkg::CMD_SWAP: begin
        if (!idx_ok) begin
          status_next = ils_pkg::ST_RANGE;
        end else begin
          // fill the hole with the last element
          ctl.mode   = ils_pkg::MODE_WRITE;
          load_data  = rd_b;
          read_next  = rd_a;
          count_next = count - CW'(1);
        end
      end
      ils_pkg::CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    // Hold the row unless a request is taken
    if (!accept) ctl.mode = ils_pkg::MODE_HOLD;
  end

  ils_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .load_data (load_data),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // Advance length and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
      rsp_read   <= ils_pkg::READ_W'(read_next);
      rsp_length <= ils_pkg::LENGTH_W'(count_next);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.read_value = rsp_read;
  assign rsp.length     = rsp_length;

endmodule

FILE: rtl/core/ils_cell.sv
// One storage cell of the list: holds one element and trades with its neighbors.
module ils_cell (
  input  logic                             clk,
  input  ils_pkg::ctl_t                    ctl,
  input  logic [ils_pkg::IDX_W-1:0]        pos,
  input  logic [ils_pkg::ELEMENT_BITS-1:0] load_data,
  input  logic [ils_pkg::ELEMENT_BITS-1:0] lower_data,
  input  logic [ils_pkg::ELEMENT_BITS-1:0] upper_data,
  output logic [ils_pkg::ELEMENT_BITS-1:0] data,
  output logic [ils_pkg::ELEMENT_BITS-1:0] rd_a,
  output logic [ils_pkg::ELEMENT_BITS-1:0] rd_b
);

  logic [ils_pkg::ELEMENT_BITS-1:0] data_next;
  logic                             at_idx;
  logic                             above_idx;

  assign at_idx    = (pos == ctl.idx);
  assign above_idx = (pos > ctl.idx);

  // Pick the next element from the row mode
  always_comb begin
    data_next = data;
    case (ctl.mode)
      ils_pkg::MODE_HOLD: data_next = data;
      ils_pkg::MODE_WRITE: begin
        if (at_idx) data_next = load_data;
      end
      ils_pkg::MODE_INSERT: begin
        if (above_idx) data_next = lower_data;
        else if (at_idx) data_next = load_data;
      end
      ils_pkg::MODE_REMOVE: begin
        if (at_idx || above_idx) data_next = upper_data;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Drive the read buses only when addressed
  assign rd_a = at_idx ? data : '0;
  assign rd_b = (pos == ctl.last) ? data : '0;

endmodule

FILE: rtl/core/ils_chain.sv
// Row of list cells with neighbor links and the two read buses.
module ils_chain (
  input  logic                             clk,
  input  ils_pkg::ctl_t                    ctl,
  input  logic [ils_pkg::ELEMENT_BITS-1:0] load_data,
  output logic [ils_pkg::ELEMENT_BITS-1:0] rd_a,
  output logic [ils_pkg::ELEMENT_BITS-1:0] rd_b
);

  localparam int N = ils_pkg::CAPACITY;
  localparam int W = ils_pkg::ELEMENT_BITS;

  logic [W-1:0] cell_data [N];
  logic [W-1:0] cell_rd_a [N];
  logic [W-1:0] cell_rd_b [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] lower;
    logic [W-1:0] upper;

    // Link to neighbors; the ends see zero
    if (i == 0) begin : g_bot
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == N - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    ils_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (ils_pkg::IDX_W'(i)),
      .load_data  (load_data),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[i]),
      .rd_a       (cell_rd_a[i]),
      .rd_b       (cell_rd_b[i])
    );
  end

  // Merge the read buses; at most one cell drives each
  always_comb begin
    rd_a = '0;
    rd_b = '0;
    for (int i = 0; i < N; i++) begin
      rd_a = rd_a | cell_rd_a[i];
      rd_b = rd_b | cell_rd_b[i];
    end
  end

endmodule
